// File: hw/rtl/scblc_pkg.sv
// Shared types, constants and the sine magnitude table for the copper bar colour generator.
package scblc_pkg;

   // Field widths
   localparam int LINE_W   = 12;
   localparam int AMP_W    = 11;
   localparam int COLOUR_W = 8;
   localparam int SINE_W   = 17;            // Q16 magnitude, up to 1.0
   localparam int PROD_W   = SINE_W + AMP_W;
   localparam int CSR_INDEX_W = 2;

   // Defaults for top-level parameters
   localparam int NUM_BARS_DEFAULT  = 12;
   localparam int BAR_LINES_DEFAULT = 15;

   // Phase circle
   localparam int PHASE_STEPS   = 360;
   localparam int PHASE_W       = $clog2(PHASE_STEPS);
   localparam int PHASE_STRIDE  = 8;
   localparam int PHASE_ADVANCE = 2;
   localparam int SINE_ENTRIES  = PHASE_STEPS / 2 + 1;
   localparam int ROM_IDX_W     = $clog2(SINE_ENTRIES);

   // Colour ramp
   localparam int INTENSITY_STEP = 'h22;
   localparam int INTENSITY_MAX  = 'hff;

   // Bar colour groups
   localparam int GROUP_BLUE  = 0;
   localparam int GROUP_WHITE = 1;

   // Register reset values
   localparam logic [LINE_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
   localparam logic [AMP_W-1:0]  AMPLITUDE_RESET    = 11'd100;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SINE_AMPLITUDE = 2'd1;

   // Request codes
   localparam logic FUNC_FRAME = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Query word moving down the bar chain
   typedef struct packed {
      logic                valid;
      logic                in_frame;
      logic [LINE_W-1:0]   line;
      logic                hit;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } query_word_type;

   // Top-line shift into the chain
   typedef struct packed {
      logic              shift;
      logic [LINE_W-1:0] top;
   } load_shift_type;

   // Fixed-point sine constants (Q30)
   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
   localparam longint unsigned PI_Q30      = 64'd3373259426;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned TAYLOR_DIVS [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   typedef logic [SINE_W-1:0] sine_rom_type [SINE_ENTRIES];

   // |sin| in Q16 for a folded phase m in 0..PHASE_STEPS/2
   function automatic logic [SINE_W-1:0] sine_mag(int unsigned m);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      x = (longint'(m) * TWO_PI_Q30 + longint'(PHASE_STEPS / 2)) / PHASE_STEPS;
      if (x > PI_Q30) x = PI_Q30;
      if (x > HALF_PI_Q30) x = PI_Q30 - x;
      x2 = (x * x) >> 30;
      t = Q30_ONE;
      for (int i = 0; i < 5; i++) begin
         t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIVS[i];
      end
      s = (x * t) >> 30;
      return SINE_W'((s + 64'd8192) >> 14);
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int m = 0; m < SINE_ENTRIES; m++) begin
         rom[m] = sine_mag(m);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// File: hw/rtl/scblc_sine_unit.sv
// Frame-start sequencer: walks the bars, looks up the sine and shifts top lines into the chain.
module scblc_sine_unit #(
   parameter int NUM_BARS = scblc_pkg::NUM_BARS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [scblc_pkg::AMP_W-1:0]    centre,
   input  logic [scblc_pkg::AMP_W-1:0]    amp,
   output scblc_pkg::load_shift_type      load,
   output logic                           busy
);

   localparam int CNT_W        = $clog2(NUM_BARS + 1);
   localparam int PW           = scblc_pkg::PHASE_W;
   localparam int START_OFFSET = scblc_pkg::PHASE_STRIDE * NUM_BARS;

   logic [PW-1:0]                  base_ff;
   logic [PW-1:0]                  phase_ff;
   logic [CNT_W-1:0]               count_ff;
   logic                           rom_valid_ff;
   logic                           prod_valid_ff;
   logic [scblc_pkg::SINE_W-1:0]   mag_ff;
   logic                           rom_neg_ff;
   logic [scblc_pkg::PROD_W-1:0]   prod_ff;
   logic                           prod_neg_ff;

   logic [PW:0]                    start_sum;
   logic [PW-1:0]                  start_phase;
   logic [PW:0]                    base_sum;
   logic [PW-1:0]                  base_in;
   logic [PW-1:0]                  phase_dec;
   logic                           fold_neg;
   logic [PW-1:0]                  fold_mag;
   logic [scblc_pkg::PROD_W:0]     round_sum;
   logic [scblc_pkg::AMP_W-1:0]    delta_dn;
   logic [scblc_pkg::AMP_W-1:0]    delta_up;

   // Phase of the highest bar, next base, next bar down
   always_comb begin
      start_sum   = {1'b0, base_ff} + (PW + 1)'(START_OFFSET);
      start_phase = (start_sum >= (PW + 1)'(scblc_pkg::PHASE_STEPS))
                  ? PW'(start_sum - (PW + 1)'(scblc_pkg::PHASE_STEPS)) : start_sum[PW-1:0];
      base_sum    = {1'b0, base_ff} + (PW + 1)'(scblc_pkg::PHASE_ADVANCE);
      base_in     = (base_sum >= (PW + 1)'(scblc_pkg::PHASE_STEPS))
                  ? PW'(base_sum - (PW + 1)'(scblc_pkg::PHASE_STEPS)) : base_sum[PW-1:0];
      phase_dec   = (phase_ff < PW'(scblc_pkg::PHASE_STRIDE))
                  ? phase_ff + PW'(scblc_pkg::PHASE_STEPS - scblc_pkg::PHASE_STRIDE)
                  : phase_ff - PW'(scblc_pkg::PHASE_STRIDE);
   end

   // Fold onto the first half circle
   always_comb begin
      fold_neg = {phase_ff, 1'b0} >= (PW + 1)'(scblc_pkg::PHASE_STEPS);
      fold_mag = fold_neg ? PW'(scblc_pkg::PHASE_STEPS) - phase_ff : phase_ff;
   end

   // Top line: centre plus floor of the scaled sine
   always_comb begin
      round_sum = {1'b0, prod_ff} + (scblc_pkg::PROD_W + 1)'(65535);
      delta_dn  = round_sum[16 +: scblc_pkg::AMP_W];
      delta_up  = prod_ff[16 +: scblc_pkg::AMP_W];
      load.shift = prod_valid_ff;
      load.top   = prod_neg_ff ? ({1'b0, centre} - {1'b0, delta_dn})
                               : ({1'b0, centre} + {1'b0, delta_up});
   end

   assign busy = (count_ff != '0) | rom_valid_ff | prod_valid_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         count_ff      <= '0;
         rom_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         rom_valid_ff  <= (count_ff != '0);
         prod_valid_ff <= rom_valid_ff;
         if (start) begin
            base_ff  <= base_in;
            count_ff <= CNT_W'(NUM_BARS);
         end else if (count_ff != '0) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Datapath: phase, ROM read, product
   always_ff @(posedge clock) begin
      if (start) begin
         phase_ff <= start_phase;
      end else if (count_ff != '0) begin
         phase_ff <= phase_dec;
      end
      mag_ff      <= scblc_pkg::SINE_ROM[fold_mag[scblc_pkg::ROM_IDX_W-1:0]];
      rom_neg_ff  <= fold_neg;
      prod_ff     <= scblc_pkg::PROD_W'(mag_ff) * scblc_pkg::PROD_W'(amp);
      prod_neg_ff <= rom_neg_ff;
   end

endmodule

// File: hw/rtl/scblc_bar_cell.sv
// One bar of the chain: holds its top line and paints a passing query word.
module scblc_bar_cell #(
   parameter int INDEX     = 0,
   parameter int NUM_BARS  = scblc_pkg::NUM_BARS_DEFAULT,
   parameter int BAR_LINES = scblc_pkg::BAR_LINES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  scblc_pkg::load_shift_type         load_in,
   output logic [scblc_pkg::LINE_W-1:0]      top_out,
   input  scblc_pkg::query_word_type         word_in,
   output scblc_pkg::query_word_type         word_out
);

   localparam int GROUP = (INDEX * 3) / NUM_BARS;
   localparam int OFF_W = $clog2(BAR_LINES + 1);

   logic [scblc_pkg::LINE_W-1:0] top_ff;
   scblc_pkg::query_word_type    word_ff;
   scblc_pkg::query_word_type    word_in_next;

   logic [scblc_pkg::LINE_W-1:0] diff;
   logic                         covered;
   logic [OFF_W-1:0]             offset;
   logic [OFF_W-1:0]             mirror;
   logic [OFF_W-1:0]             ramp_pos;
   logic [15:0]                  ramp;
   logic [scblc_pkg::COLOUR_W-1:0] level;

   // Coverage and ramp intensity
   always_comb begin
      diff     = word_in.line - top_ff;
      covered  = word_in.valid && word_in.in_frame && (word_in.line >= top_ff)
                 && (diff < scblc_pkg::LINE_W'(BAR_LINES));
      offset   = diff[OFF_W-1:0];
      mirror   = OFF_W'(BAR_LINES - 1) - offset;
      ramp_pos = (offset < mirror) ? offset : mirror;
      ramp     = (16'(ramp_pos) + 16'd1) * 16'(scblc_pkg::INTENSITY_STEP);
      level    = (ramp > 16'(scblc_pkg::INTENSITY_MAX))
               ? scblc_pkg::COLOUR_W'(scblc_pkg::INTENSITY_MAX) : ramp[scblc_pkg::COLOUR_W-1:0];
   end

   // Later bars override earlier ones
   always_comb begin
      word_in_next = word_in;
      if (covered) begin
         word_in_next.hit = 1'b1;
         case (GROUP)
            scblc_pkg::GROUP_BLUE: begin
               word_in_next.red   = '0;
               word_in_next.green = '0;
               word_in_next.blue  = level;
            end
            scblc_pkg::GROUP_WHITE: begin
               word_in_next.red   = level;
               word_in_next.green = level;
               word_in_next.blue  = level;
            end
            default: begin
               word_in_next.red   = level;
               word_in_next.green = '0;
               word_in_next.blue  = '0;
            end
         endcase
      end
   end

   // Top line shift register
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else if (load_in.shift) begin
         top_ff <= load_in.top;
      end
   end

   // Query word stage; only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff.valid <= word_in_next.valid;
      end
      if (advance) begin
         word_ff.in_frame <= word_in_next.in_frame;
         word_ff.line     <= word_in_next.line;
         word_ff.hit      <= word_in_next.hit;
         word_ff.red      <= word_in_next.red;
         word_ff.green    <= word_in_next.green;
         word_ff.blue     <= word_in_next.blue;
      end
   end

   assign top_out  = top_ff;
   assign word_out = word_ff;

endmodule

// File: hw/rtl/sine_copper_bar_line_colour.sv
// Top level of the copper bar scanline colour generator.
//
//  channel  direction  handshake          payload
//  req      in         req_valid/ready    req_func, req_line_index
//  rsp      out        rsp_valid/ready    rsp_red, rsp_green, rsp_blue, rsp_bar_hit
//  csr      in         csr_write_enable   csr_index, csr_write_data
//
// A line query walks the chain of NUM_BARS cells, one cell a cycle, and one query is
// accepted per cycle; a stalled rsp freezes the whole chain and blocks new requests. A
// frame start waits until the chain is empty, then the sine unit feeds one top line a
// cycle; requests wait until it is done. Reset is synchronous; all top lines reset to 0.
module sine_copper_bar_line_colour #(
   parameter int NUM_BARS  = scblc_pkg::NUM_BARS_DEFAULT,
   parameter int BAR_LINES = scblc_pkg::BAR_LINES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [scblc_pkg::LINE_W-1:0]        req_line_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [scblc_pkg::COLOUR_W-1:0]      rsp_red,
   output logic [scblc_pkg::COLOUR_W-1:0]      rsp_green,
   output logic [scblc_pkg::COLOUR_W-1:0]      rsp_blue,
   output logic                                rsp_bar_hit,
   input  logic                                csr_write_enable,
   input  logic [scblc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scblc_pkg::LINE_W-1:0]        csr_write_data
);

   logic [scblc_pkg::LINE_W-1:0] frame_height_ff;
   logic [scblc_pkg::AMP_W-1:0]  amplitude_ff;
   logic [scblc_pkg::AMP_W-1:0]  centre;
   logic [scblc_pkg::AMP_W-1:0]  amp_sat;

   scblc_pkg::query_word_type    words [NUM_BARS+1];
   scblc_pkg::load_shift_type    loads [NUM_BARS];
   scblc_pkg::load_shift_type    sine_load;
   logic [scblc_pkg::LINE_W-1:0] tops  [NUM_BARS];
   logic [NUM_BARS-1:0]          stage_valid;

   logic advance;
   logic chain_busy;
   logic loader_busy;
   logic frame_accept;
   logic query_accept;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_height_ff <= scblc_pkg::FRAME_HEIGHT_RESET;
         amplitude_ff    <= scblc_pkg::AMPLITUDE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            scblc_pkg::REG_FRAME_HEIGHT:   frame_height_ff <= csr_write_data;
            scblc_pkg::REG_SINE_AMPLITUDE: amplitude_ff <= csr_write_data[scblc_pkg::AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Centre line and saturated swing
   assign centre  = frame_height_ff[scblc_pkg::LINE_W-1:1];
   assign amp_sat = (amplitude_ff > centre) ? centre : amplitude_ff;

   // Handshake
   assign advance      = !words[NUM_BARS].valid || rsp_ready;
   assign chain_busy   = |stage_valid;
   assign req_ready    = advance && !loader_busy
                         && ((req_func == scblc_pkg::FUNC_QUERY) || !chain_busy);
   assign frame_accept = req_valid && req_ready && (req_func == scblc_pkg::FUNC_FRAME);
   assign query_accept = req_valid && req_ready && (req_func == scblc_pkg::FUNC_QUERY);

   // Word entering the chain
   always_comb begin
      words[0].valid    = query_accept;
      words[0].in_frame = req_line_index < frame_height_ff;
      words[0].line     = req_line_index;
      words[0].hit      = 1'b0;
      words[0].red      = '0;
      words[0].green    = '0;
      words[0].blue     = '0;
   end

   scblc_sine_unit #(
      .NUM_BARS (NUM_BARS)
   ) u_sine (
      .clock  (clock),
      .reset  (reset),
      .start  (frame_accept),
      .centre (centre),
      .amp    (amp_sat),
      .load   (sine_load),
      .busy   (loader_busy)
   );

   // Chain of bar cells
   for (genvar j = 0; j < NUM_BARS; j++) begin : g_cell
      if (j == 0) begin : g_head
         assign loads[j] = sine_load;
      end else begin : g_body
         assign loads[j] = '{shift: sine_load.shift, top: tops[j-1]};
      end

      scblc_bar_cell #(
         .INDEX     (j),
         .NUM_BARS  (NUM_BARS),
         .BAR_LINES (BAR_LINES)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .load_in  (loads[j]),
         .top_out  (tops[j]),
         .word_in  (words[j]),
         .word_out (words[j+1])
      );

      assign stage_valid[j] = words[j+1].valid;
   end

   // Result word
   assign rsp_valid   = words[NUM_BARS].valid;
   assign rsp_red     = words[NUM_BARS].red;
   assign rsp_green   = words[NUM_BARS].green;
   assign rsp_blue    = words[NUM_BARS].blue;
   assign rsp_bar_hit = words[NUM_BARS].hit;

   // Checks
   a_frame_starts_loader: assert property (@(posedge clock) disable iff (reset)
      frame_accept |=> loader_busy)
      else $error("frame start did not start the sine unit");

   a_frame_on_empty_chain: assert property (@(posedge clock) disable iff (reset)
      frame_accept |-> !chain_busy)
      else $error("frame start taken with queries in flight");

   a_no_query_during_load: assert property (@(posedge clock) disable iff (reset)
      loader_busy |-> !chain_busy)
      else $error("query in chain while top lines shift");

   a_query_enters_chain: assert property (@(posedge clock) disable iff (reset)
      query_accept |=> words[1].valid)
      else $error("accepted query lost at chain head");

endmodule
